// ===== hdl/dmvc_pkg.sv =====
// Shared types and constants of the direct-mapped value cache.
`default_nettype none

package dmvc_pkg;

   localparam int DMVC_ENTRIES   = 1024;
   localparam int KEY_W          = 64;
   localparam int VALUE_W        = 32;
   localparam int TASK_W         = 16;
   localparam int COUNT_W        = 32;
   localparam int USED_OUT_W     = 11;
   localparam int USED_FIELD_MAX = 2047;
   localparam int SLOT_W         = KEY_W + VALUE_W + TASK_W;
   localparam int REQ_DATA_W     = 112;
   localparam int RSP_DATA_W     = 112;

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_LOAD  = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic commit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic out_stall;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== hdl/dmvc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module dmvc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/dmvc_datapath.sv =====
// Datapath of the value cache: slot memory, request and result registers, counters.
`default_nettype none

module dmvc_datapath
   import dmvc_pkg::*;
#(
   parameter int ENTRIES = DMVC_ENTRIES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dp_cmd_type            cmd,
   output dp_stat_type                stat,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   output logic                       rsp_tuser
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int USED_W = $clog2(ENTRIES + 1);

   logic [IDX_W-1:0]   clear_cnt_ff, clear_cnt_in;
   logic               cmd_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [TASK_W-1:0]  task_ff;

   logic [COUNT_W-1:0] hit_ff, hit_in;
   logic [COUNT_W-1:0] miss_ff, miss_in;
   logic [USED_W-1:0]  used_ff, used_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff;
   logic [VALUE_W-1:0]    rsp_value_ff;
   logic [COUNT_W-1:0]    rsp_hit_ff;
   logic [COUNT_W-1:0]    rsp_miss_ff;
   logic [USED_OUT_W-1:0] rsp_used_ff;

   logic [KEY_W-1:0]   req_key;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [SLOT_W-1:0]  wr_data;
   logic [SLOT_W-1:0]  rd_data;
   logic [KEY_W-1:0]   rd_key;
   logic [VALUE_W-1:0] rd_value;
   logic [TASK_W-1:0]  rd_task;
   logic               is_store;
   logic               hit;
   logic               was_used;
   logic               now_used;
   logic               ok;
   logic [VALUE_W-1:0] load_value;
   logic [31:0]        used_wide;
   logic [USED_OUT_W-1:0] used_out;

   assign req_key = req_tdata[KEY_W-1:0];

   assign rd_key   = rd_data[KEY_W-1:0];
   assign rd_value = rd_data[KEY_W +: VALUE_W];
   assign rd_task  = rd_data[KEY_W+VALUE_W +: TASK_W];

   assign is_store = (cmd_ff == CMD_STORE);
   assign hit      = (rd_key == key_ff) && (rd_task == task_ff);
   assign was_used = (rd_key != '0);
   assign now_used = (key_ff != '0);

   // During the clearing pass the write port sweeps the memory with zeros.
   assign wr_en   = cmd.clear_wr || (cmd.commit && is_store);
   assign wr_addr = cmd.clear_wr ? clear_cnt_ff : key_ff[IDX_W-1:0];
   assign wr_data = cmd.clear_wr ? '0 : {task_ff, value_ff, key_ff};

   dmvc_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (req_key[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      clear_cnt_in = cmd.clear_wr ? clear_cnt_ff + 1'b1 : clear_cnt_ff;

      hit_in  = hit_ff;
      miss_in = miss_ff;
      used_in = used_ff;
      if (cmd.commit) begin
         if (is_store) begin
            if (!was_used && now_used) begin
               used_in = used_ff + 1'b1;
            end else if (was_used && !now_used && used_ff != '0) begin
               used_in = used_ff - 1'b1;
            end
         end else if (hit) begin
            if (hit_ff != '1) begin
               hit_in = hit_ff + 1'b1;
            end
         end else begin
            if (miss_ff != '1) begin
               miss_in = miss_ff + 1'b1;
            end
         end
      end

      ok         = is_store || hit;
      load_value = (!is_store && hit) ? rd_value : '0;
      used_wide  = 32'(used_in);
      used_out   = (used_wide > 32'(USED_FIELD_MAX)) ? USED_OUT_W'(USED_FIELD_MAX)
                                                      : used_wide[USED_OUT_W-1:0];

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_cnt_ff <= clear_cnt_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff   <= req_tuser;
         key_ff   <= req_key;
         value_ff <= req_tdata[KEY_W +: VALUE_W];
         task_ff  <= req_tdata[KEY_W+VALUE_W +: TASK_W];
      end
      if (cmd.commit) begin
         rsp_ok_ff    <= ok;
         rsp_value_ff <= load_value;
         rsp_hit_ff   <= hit_in;
         rsp_miss_ff  <= miss_in;
         rsp_used_ff  <= used_out;
      end
   end

   assign stat.clear_last = (clear_cnt_ff == IDX_W'(ENTRIES - 1));
   assign stat.out_stall  = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {(RSP_DATA_W - VALUE_W - 2*COUNT_W - USED_OUT_W)'(0),
                        rsp_used_ff, rsp_miss_ff, rsp_hit_ff, rsp_value_ff};

endmodule

`default_nettype wire

// ===== hdl/dmvc_ctrl.sv =====
// Controller of the value cache: clearing pass, request intake and commit sequencing.
`default_nettype none

module dmvc_ctrl
   import dmvc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // The slot word read at intake is valid now; wait only for room at the output.
            if (!stat.out_stall) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/direct_mapped_value_cache.sv =====
// Top level of the direct-mapped value cache.
`default_nettype none

// Direct-mapped cache of 32-bit values under 64-bit keys and 16-bit task ids. The
// slot is the low log2(ENTRIES) key bits (ENTRIES must be a power of two). A store
// (req_tuser 0) overwrites the slot; a load (req_tuser 1) hits when both key and
// task id match. After reset the block zeroes all ENTRIES slots (1024 by default) of
// the slot memory and holds req_tready low meanwhile. ST_IDLE then captures each word
// and reads its slot; ST_UPDATE compares and writes back once the output has room, a
// split set by the registered read of the single slot memory. No word is taken before
// the last is committed. A finished result waits in an output register, so intake
// goes on while the result side stalls, up to one held result.

module direct_mapped_value_cache
   import dmvc_pkg::*;
#(
   parameter int ENTRIES = DMVC_ENTRIES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // key [63:0], store_value [95:64], task_id [111:96]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // command [0]
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // load_value [31:0], hit_total [63:32], miss_total [95:64], used_total [106:96], zeros
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   // ok [0]
   output logic                       rsp_tuser
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   dmvc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dmvc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== hdl/dmvc_checker.sv =====
// Port-level checks of the value cache and their binding to the top level.
`default_nettype none

module dmvc_checker
   import dmvc_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser
);

   // Reset starts the clearing pass: nothing taken, nothing offered.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("cache active right after reset");

   // Only one word is in work at a time.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while one is in work");

   // A miss never returns a value.
   a_miss_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[VALUE_W-1:0] == '0)
      else $error("load miss carries a nonzero value");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind direct_mapped_value_cache dmvc_checker u_dmvc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== bench/direct_mapped_value_cache_tb.sv =====
// Self-checking testbench for the direct-mapped value cache: directed words, then random traffic.
module direct_mapped_value_cache_tb;
   import dmvc_pkg::*;

   localparam int SLOT_BITS    = $clog2(DMVC_ENTRIES);
   localparam int RANDOM_WORDS = 1850;
   localparam int STALL_LIMIT  = 5000;
   localparam int RECENT_DEPTH = 32;

   typedef struct packed {
      logic               cmd;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic [TASK_W-1:0]  task_id;
   } cache_req_type;

   typedef struct packed {
      logic                  ok;
      logic [VALUE_W-1:0]    load_value;
      logic [COUNT_W-1:0]    hits;
      logic [COUNT_W-1:0]    misses;
      logic [USED_OUT_W-1:0] used;
   } cache_rsp_type;

   typedef struct {
      cache_req_type rq;
      bit            typed;
      cache_rsp_type rs;
   } script_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   always #10 clock = ~clock;

   direct_mapped_value_cache dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Shadow copy of the slot memory and counters.
   logic [KEY_W-1:0]   shadow_key   [DMVC_ENTRIES];
   logic [VALUE_W-1:0] shadow_value [DMVC_ENTRIES];
   logic [TASK_W-1:0]  shadow_task  [DMVC_ENTRIES];
   logic [COUNT_W-1:0] hits_seen   = '0;
   logic [COUNT_W-1:0] misses_seen = '0;
   int                 slots_in_use = 0;

   cache_rsp_type      waiting_rsps[$];
   int                 mismatches  = 0;
   int                 stores_sent = 0;
   int                 loads_sent  = 0;
   int                 idle_cycles = 0;
   bit                 steady      = 1'b0;

   // Recently stored key and task id pairs, for loads that should hit.
   logic [KEY_W-1:0]   recent_key  [RECENT_DEPTH];
   logic [TASK_W-1:0]  recent_task [RECENT_DEPTH];
   int                 recent_fill = 0;
   int                 recent_head = 0;

   function automatic cache_rsp_type cache_access(input cache_req_type rq);
      logic [SLOT_BITS-1:0] slot;
      cache_rsp_type        rs;
      slot = rq.key[SLOT_BITS-1:0];
      rs = '0;
      rs.ok = 1'b1;
      if (rq.cmd == CMD_STORE) begin
         if (shadow_key[slot] == '0 && rq.key != '0)
            slots_in_use++;
         else if (shadow_key[slot] != '0 && rq.key == '0 && slots_in_use > 0)
            slots_in_use--;
         shadow_key[slot]   = rq.key;
         shadow_value[slot] = rq.value;
         shadow_task[slot]  = rq.task_id;
      end else if (shadow_key[slot] == rq.key && shadow_task[slot] == rq.task_id) begin
         rs.load_value = shadow_value[slot];
         if (hits_seen != '1)
            hits_seen = hits_seen + 1'b1;
      end else begin
         rs.ok = 1'b0;
         if (misses_seen != '1)
            misses_seen = misses_seen + 1'b1;
      end
      rs.hits   = hits_seen;
      rs.misses = misses_seen;
      rs.used   = (slots_in_use > USED_FIELD_MAX) ? USED_OUT_W'(USED_FIELD_MAX)
                                                  : USED_OUT_W'(slots_in_use);
      return rs;
   endfunction

   function automatic script_row_type row(input logic cmd, input logic [KEY_W-1:0] key,
                                          input logic [VALUE_W-1:0] value,
                                          input logic [TASK_W-1:0] task_id,
                                          input bit typed = 1'b0, input logic ok = 1'b0,
                                          input logic [VALUE_W-1:0] load_value = '0,
                                          input logic [COUNT_W-1:0] hits = '0,
                                          input logic [COUNT_W-1:0] misses = '0,
                                          input logic [USED_OUT_W-1:0] used = '0);
      script_row_type r;
      r.rq = '{cmd: cmd, key: key, value: value, task_id: task_id};
      r.typed = typed;
      r.rs = '{ok: ok, load_value: load_value, hits: hits, misses: misses, used: used};
      return r;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] k;
      k = {$urandom, $urandom};
      // Crowd half of the keys into a few slots so that overwrites are common.
      if ($urandom_range(1) == 1)
         k[SLOT_BITS-1:0] = SLOT_BITS'($urandom_range(15));
      return k;
   endfunction

   task automatic send_word(input cache_req_type rq, input bit typed,
                            input cache_rsp_type typed_rsp);
      cache_rsp_type predicted;
      if (!steady)
         while ($urandom_range(99) < 25) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.cmd;
      req_tdata  <= {rq.task_id, rq.value, rq.key};
      do @(posedge clock); while (!req_tready);
      predicted = cache_access(rq);
      waiting_rsps.push_back(typed ? typed_rsp : predicted);
      if (rq.cmd == CMD_STORE)
         stores_sent++;
      else
         loads_sent++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (steady)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= ($urandom_range(99) >= 25);
   end

   always @(posedge clock) begin
      cache_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (waiting_rsps.size() == 0) begin
            $error("result word arrived with nothing outstanding");
            mismatches++;
         end else begin
            want = waiting_rsps.pop_front();
            compare_field("ok", 64'(want.ok), 64'(rsp_tuser));
            compare_field("load_value", 64'(want.load_value), 64'(rsp_tdata[31:0]));
            compare_field("hit_total", 64'(want.hits), 64'(rsp_tdata[63:32]));
            compare_field("miss_total", 64'(want.misses), 64'(rsp_tdata[95:64]));
            compare_field("used_total", 64'(want.used), 64'(rsp_tdata[106:96]));
         end
      end
   end

   // The clearing pass after reset, which keeps req_tready low, ends well under the limit.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      script_row_type script[$];
      cache_req_type  rq;
      int             choice;
      int             pick;
      for (int i = 0; i < DMVC_ENTRIES; i++) begin
         shadow_key[i]   = '0;
         shadow_value[i] = '0;
         shadow_task[i]  = '0;
      end

      // A cleared slot holds key zero and task id zero, so the first load hits.
      script.push_back(row(CMD_LOAD, 64'h0, 32'h0, 16'h0, 1, 1, 32'h0, 1, 0, 0));
      script.push_back(row(CMD_LOAD, 64'h0, 32'h0, 16'h1, 1, 0, 32'h0, 1, 1, 0));
      script.push_back(row(CMD_STORE, '1, '1, '1, 1, 1, 32'h0, 1, 1, 1));
      script.push_back(row(CMD_LOAD, '1, 32'h0, '1, 1, 1, '1, 2, 1, 1));
      script.push_back(row(CMD_LOAD, '1, 32'h0, 16'hFFFE, 1, 0, 32'h0, 2, 2, 1));
      // Overwriting a used slot leaves the used count alone.
      script.push_back(row(CMD_STORE, 64'h3FF, 32'h1234_5678, 16'h0, 1, 1, 32'h0, 2, 2, 1));
      script.push_back(row(CMD_LOAD, '1, 32'h0, '1, 1, 0, 32'h0, 2, 3, 1));
      script.push_back(row(CMD_LOAD, 64'h3FF, 32'h0, 16'h0, 1, 1, 32'h1234_5678, 3, 3, 1));
      // Storing key zero over an empty slot does not count as use.
      script.push_back(row(CMD_STORE, 64'h0, 32'hA5A5_A5A5, 16'h7, 1, 1, 32'h0, 3, 3, 1));
      script.push_back(row(CMD_LOAD, 64'h0, 32'h0, 16'h7, 1, 1, 32'hA5A5_A5A5, 4, 3, 1));
      script.push_back(row(CMD_LOAD, 64'h0, 32'h0, 16'h0, 1, 0, 32'h0, 4, 4, 1));
      script.push_back(row(CMD_STORE, 64'h8000_0000_0000_0400, 32'h1, 16'h1,
                           1, 1, 32'h0, 4, 4, 2));
      // Storing key zero over a used slot lowers the used count.
      script.push_back(row(CMD_STORE, 64'h0, 32'h0, 16'h0, 1, 1, 32'h0, 4, 4, 1));
      script.push_back(row(CMD_STORE, 64'h400, 32'hDEAD_BEEF, 16'h8000, 1, 1, 32'h0, 4, 4, 2));
      script.push_back(row(CMD_LOAD, 64'h800, 32'h0, 16'h8000, 1, 0, 32'h0, 4, 5, 2));
      script.push_back(row(CMD_STORE, 64'h3FF, 32'h0, 16'h0, 1, 1, 32'h0, 4, 5, 2));
      script.push_back(row(CMD_LOAD, 64'h3FF, 32'h0, 16'h0, 1, 1, 32'h0, 5, 5, 2));
      script.push_back(row(CMD_STORE, 64'h5555_AAAA_5555_AAAA, 32'h5555_AAAA, 16'hAAAA));
      script.push_back(row(CMD_LOAD, 64'h5555_AAAA_5555_AAAA, 32'h0, 16'hAAAA));
      script.push_back(row(CMD_STORE, 64'hAAAA_5555_AAAA_5555, 32'hAAAA_5555, 16'h5555));
      script.push_back(row(CMD_LOAD, 64'hAAAA_5555_AAAA_5555, 32'hFFFF_FFFF, 16'h5555));
      script.push_back(row(CMD_LOAD, 64'h400, 32'h0, 16'h8000));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i])
         send_word(script[i].rq, script[i].typed, script[i].rs);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         steady = (n >= 700 && n < 1000);
         choice = $urandom_range(99);
         rq.cmd     = CMD_LOAD;
         rq.value   = $urandom;
         rq.task_id = TASK_W'($urandom);
         rq.key     = pick_key();
         pick       = (recent_fill > 0) ? $urandom_range(recent_fill - 1) : 0;
         if (choice < 35 || recent_fill == 0) begin
            rq.cmd = CMD_STORE;
            recent_key[recent_head]  = rq.key;
            recent_task[recent_head] = rq.task_id;
            recent_head = (recent_head + 1) % RECENT_DEPTH;
            if (recent_fill < RECENT_DEPTH)
               recent_fill++;
         end else if (choice < 42) begin
            rq.cmd = CMD_STORE;
            rq.key = '0;
         end else if (choice < 78) begin
            rq.key     = recent_key[pick];
            rq.task_id = recent_task[pick];
         end else if (choice < 88) begin
            // Right slot, but either the task id or the upper key bits differ.
            rq.key     = recent_key[pick];
            rq.task_id = recent_task[pick];
            if ($urandom_range(1) == 1)
               rq.task_id[$urandom_range(TASK_W - 1)] ^= 1'b1;
            else
               rq.key[KEY_W-1:SLOT_BITS] ^= (KEY_W - SLOT_BITS)'({$urandom, $urandom} | 1);
         end else if (choice < 92) begin
            rq.key     = '0;
            rq.task_id = ($urandom_range(1) == 1) ? '0 : rq.task_id;
         end
         send_word(rq, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (waiting_rsps.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d stores and %0d loads, of which %0d hit and %0d missed.",
               stores_sent, loads_sent, hits_seen, misses_seen);
      $display("Ended with %0d slots holding a nonzero key; %0d field mismatches.",
               slots_in_use, mismatches);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/dmvc_pkg.sv
hdl/dmvc_ram.sv
hdl/dmvc_datapath.sv
hdl/dmvc_ctrl.sv
hdl/direct_mapped_value_cache.sv
hdl/dmvc_checker.sv
bench/direct_mapped_value_cache_tb.sv
